// ----- sv/ohtab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtab_pkg: shared types and constants of the open addressing hash table
// Table geometry, operation and status codes, and the controller to
// datapath command and status bundles.
// ----------------------------------------------------------------------------
package ohtab_pkg;

  // table geometry (slot count is a power of two, home slot = low key bits)
  localparam int TABLE_SIZE = 32;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int SLOT_OUT_W = 5;
  localparam int KEY_W      = 31;
  localparam int REC_W      = 32;
  localparam int ENTRY_W    = KEY_W + REC_W;

  // operation codes on the cmd port
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  // insert policy held in the mode register
  typedef enum logic [1:0] {
    MODE_DIRECT    = 2'd0,
    MODE_LINEAR    = 2'd1,
    MODE_QUADRATIC = 2'd2,
    MODE_DOUBLE    = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_FOUND = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // source of the reported slot
  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_PROBE = 2'd1,
    SEL_HOME  = 2'd2
  } slot_sel_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CLEAR,
    S_READ,
    S_COMPARE,
    S_MISS
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      step;
    logic      write;
    logic      clear;
    logic      emit;
    status_t   emit_status;
    slot_sel_t emit_sel;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic direct;
    logic free;
    logic last;
    logic match;
  } dp_stat_t;

endpackage

// ----- sv/ohtab_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtab_ram: generic single write port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module ohtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ohtab_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtab_ctrl: operation sequencer
// Accepts a command, walks the probe loop or the search read, and tells the
// datapath when to write, clear and issue the result.
// ----------------------------------------------------------------------------
module ohtab_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         cmd,
  input  ohtab_pkg::dp_stat_t stat,
  output ohtab_pkg::dp_cmd_t  ctl,
  output logic               busy
);
  import ohtab_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next      = state;
    ctl             = '0;
    ctl.emit_status = ST_MISS;
    ctl.emit_sel    = SEL_ZERO;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          unique case (op_t'(cmd))
            OP_INSERT: state_next = S_PROBE;
            OP_REMOVE: state_next = S_CLEAR;
            OP_SEARCH: state_next = S_READ;
            default:   state_next = S_MISS;
          endcase
        end
      end
      S_PROBE: begin
        priority if (stat.direct || stat.free) begin
          ctl.write       = 1'b1;
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_DONE;
          ctl.emit_sel    = SEL_PROBE;
          state_next      = S_IDLE;
        end else if (stat.last) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_FULL;
          ctl.emit_sel    = SEL_ZERO;
          state_next      = S_IDLE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_CLEAR: begin
        ctl.clear       = 1'b1;
        ctl.emit        = 1'b1;
        ctl.emit_status = ST_DONE;
        ctl.emit_sel    = SEL_HOME;
        state_next      = S_IDLE;
      end
      S_READ: begin
        state_next = S_COMPARE;
      end
      S_COMPARE: begin
        ctl.emit = 1'b1;
        if (stat.match) begin
          ctl.emit_status = ST_FOUND;
          ctl.emit_sel    = SEL_HOME;
        end
        state_next = S_IDLE;
      end
      S_MISS: begin
        ctl.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // every result ends the operation
  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> state == S_IDLE)
    else $error("controller stayed busy after issuing a result");

  // a blocked probe that is not the last keeps probing
  a_probe_continues: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && !stat.direct && !stat.free && !stat.last) |=> state == S_PROBE)
    else $error("probe loop left early");

  // only an idle controller loads a new command
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !busy)
    else $error("command loaded while busy");

endmodule

// ----- sv/ohtab_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtab_dp: hash table datapath
// Holds the mode register, the occupied bits, the entry RAM, the probe
// address walker and the result registers.
// ----------------------------------------------------------------------------
module ohtab_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [1:0]                       cfg_data,
  input  logic [ohtab_pkg::KEY_W-1:0]      key,
  input  logic [ohtab_pkg::REC_W-1:0]      record,
  input  ohtab_pkg::dp_cmd_t               ctl,
  output ohtab_pkg::dp_stat_t              stat,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [ohtab_pkg::SLOT_OUT_W-1:0] slot
);
  import ohtab_pkg::*;

  mode_t                mode;
  logic [TABLE_SIZE-1:0] occ;
  logic [SLOT_W-1:0]    home;
  logic [SLOT_W-1:0]    probe;
  logic [SLOT_W-1:0]    delta;
  logic [SLOT_W-1:0]    cnt;
  logic [KEY_W-1:0]     key_r;
  logic [REC_W-1:0]     rec_r;
  logic [ENTRY_W-1:0]   rdata;
  status_t              status_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [SLOT_W-1:0]    key_home;

  assign key_home = key[SLOT_W-1:0];

  // insert policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DIRECT;
    end else if (cfg_valid && cfg_ready) begin
      mode <= mode_t'(cfg_data);
    end
  end

  // operand capture and probe walker: next probe = probe + delta mod size
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= key;
      rec_r <= record;
      home  <= key_home;
      probe <= key_home;
      cnt   <= '0;
      unique case (mode)
        MODE_QUADRATIC: delta <= SLOT_W'(2);
        MODE_DOUBLE:    delta <= key_home;
        default:        delta <= SLOT_W'(1);
      endcase
    end else if (ctl.step) begin
      probe <= probe + delta;
      cnt   <= cnt + SLOT_W'(1);
      if (mode == MODE_QUADRATIC) begin
        delta <= delta + SLOT_W'(2);
      end
    end
  end

  // occupied bits
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (ctl.write) begin
      occ[probe] <= 1'b1;
    end else if (ctl.clear) begin
      occ[home] <= 1'b0;
    end
  end

  // key and record words, read at the home slot for search
  ohtab_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ctl.write),
    .waddr (probe),
    .wdata ({rec_r, key_r}),
    .raddr (home),
    .rdata (rdata)
  );

  // status back to the controller
  assign stat.direct = (mode == MODE_DIRECT);
  assign stat.free   = !occ[probe];
  assign stat.last   = (cnt == SLOT_W'(TABLE_SIZE - 1));
  assign stat.match  = occ[home] && (rdata[KEY_W-1:0] == key_r);

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status_r <= ctl.emit_status;
      unique case (ctl.emit_sel)
        SEL_PROBE: slot_r <= probe;
        SEL_HOME:  slot_r <= home;
        default:   slot_r <= '0;
      endcase
    end
  end

  assign status = status_r;
  assign slot   = SLOT_OUT_W'(slot_r);

  // done never stays high: results are never issued back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back to back result strobes");

  // full and miss results report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL || status == ST_MISS)) |-> slot == '0)
    else $error("nonzero slot on full or miss result");

  // probing inserts only fill free slots
  a_probe_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.write && mode != MODE_DIRECT) |-> !occ[probe])
    else $error("probing insert overwrote an occupied slot");

endmodule

// ----- sv/open_addressing_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table: 32 slot hash table with probing inserts
// Insert, remove and search on keys whose home slot is the key mod 32.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken when start is high and busy is
//   low; cmd, key and record are sampled at that edge.
//   Config channel: cfg_data sets the insert policy when cfg_valid and
//   cfg_ready are high; cfg_ready is always high, write it while idle.
//   Result channel: status and slot are valid for the single cycle done is
//   high; the receiver cannot stall and must take it then.
// Steps from acceptance to the done strobe (done is registered):
//   remove, direct insert, unused command: S_CLEAR, S_PROBE or S_MISS issues
//   the result; search: S_READ then S_COMPARE (registered RAM read);
//   probing insert: k = 1 to 32 probes, one probe of the occupied bits per cycle.
//   Busy drops in the done cycle, so the next command can be taken then.
// Reset: synchronous rst empties every slot at once (occupied bits clear),
//   selects direct insert and drops any operation in flight.
// ----------------------------------------------------------------------------
module open_addressing_hash_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       cmd,
  input  logic [ohtab_pkg::KEY_W-1:0]      key,
  input  logic [ohtab_pkg::REC_W-1:0]      record,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_data,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [ohtab_pkg::SLOT_OUT_W-1:0] slot
);
  import ohtab_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // configuration is always writable
  assign cfg_ready = 1'b1;

  // sequencer
  ohtab_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // storage, probe walker and result registers
  ohtab_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .key       (key),
    .record    (record),
    .ctl       (ctl),
    .stat      (stat),
    .done      (done),
    .status    (status),
    .slot      (slot)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the open addressing hash table
// Sends insert, remove, search and unused commands under all four insert
// policies. A behavioral copy of the table predicts status and slot for
// each accepted command. The result checker compares every done strobe
// with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ohtab_pkg::*;

  // one predicted result
  typedef struct {
    status_t                st;
    logic [SLOT_OUT_W-1:0]  sl;
  } outcome_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             cmd;
  logic [KEY_W-1:0]       key;
  logic [REC_W-1:0]       record;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_data;
  logic                   done;
  logic [1:0]             status;
  logic [SLOT_OUT_W-1:0]  slot;

  // behavioral copy of the table
  logic [31:0]            key_word [TABLE_SIZE];
  bit                     slot_used [TABLE_SIZE];
  mode_t                  insert_policy;

  outcome_t               expected_outcomes[$];
  outcome_t               oldest;
  logic [KEY_W-1:0]       stored_keys[$];
  bit                     idling;
  int                     error_count;
  int                     commands_sent;
  int                     status_seen [4];

  open_addressing_hash_table uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .key       (key),
    .record    (record),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .status    (status),
    .slot      (slot)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predict one command and update the table copy
  function automatic outcome_t predict_table_op(input op_t op, input logic [KEY_W-1:0] k);
    outcome_t    res;
    int unsigned home;
    int unsigned probe;
    bit          placed;
    res.st = ST_MISS;
    res.sl = '0;
    home = k % TABLE_SIZE;
    placed = 1'b0;
    case (op)
      OP_INSERT: begin
        if (insert_policy == MODE_DIRECT) begin
          key_word[home] = {1'b0, k};
          slot_used[home] = 1'b1;
          res.st = ST_DONE;
          res.sl = home[SLOT_OUT_W-1:0];
        end else begin
          res.st = ST_FULL;
          for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
            case (insert_policy)
              MODE_LINEAR:    probe = (home + i) % TABLE_SIZE;
              MODE_QUADRATIC: probe = (home + i + i * i) % TABLE_SIZE;
              default:        probe = (home + i * home) % TABLE_SIZE;
            endcase
            // first free slot along the probe sequence wins
            if (!placed && !slot_used[probe]) begin
              placed = 1'b1;
              key_word[probe] = {1'b0, k};
              slot_used[probe] = 1'b1;
              res.st = ST_DONE;
              res.sl = probe[SLOT_OUT_W-1:0];
            end
          end
        end
      end
      OP_REMOVE: begin
        key_word[home] = 32'hFFFF_FFFF;
        slot_used[home] = 1'b0;
        res.st = ST_DONE;
        res.sl = home[SLOT_OUT_W-1:0];
      end
      OP_SEARCH: begin
        // only the home slot is looked at
        if (key_word[home] == {1'b0, k}) begin
          res.st = ST_FOUND;
          res.sl = home[SLOT_OUT_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // send one command transaction, with an optional idle burst first
  task automatic issue_command(input op_t op, input logic [KEY_W-1:0] k,
                               input logic [REC_W-1:0] rec);
    int          gap;
    logic [31:0] junk;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        junk = $urandom;
        start  <= 1'b0;
        cmd    <= junk[1:0];
        key    <= junk[KEY_W-1:0];
        record <= $urandom;
      end
    end
    @(negedge clk);
    start  <= 1'b1;
    cmd    <= op;
    key    <= k;
    record <= rec;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_outcomes.push_back(predict_table_op(op, k));
    commands_sent++;
    if (op == OP_INSERT) begin
      stored_keys.push_back(k);
      if (stored_keys.size() > 48) void'(stored_keys.pop_front());
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_table_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // write the insert policy register while idle
  task automatic set_insert_policy(input mode_t m);
    wait_table_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    insert_policy = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 2'($urandom);
  endtask

  // random key: mostly small keys below 256 over all home slots, some reused, some wide
  function automatic logic [KEY_W-1:0] pick_key();
    logic [31:0] r;
    int          roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      r = $urandom;
    end else if (roll < 5 && stored_keys.size() != 0) begin
      r = {1'b0, stored_keys[$urandom_range(0, stored_keys.size() - 1)]};
    end else begin
      r = ($urandom_range(0, 7) << SLOT_W) | $urandom_range(0, TABLE_SIZE - 1);
    end
    return r[KEY_W-1:0];
  endfunction

  // searches, removes and unused commands on a fresh table
  task automatic test_empty_table();
    issue_command(OP_SEARCH, '0, '0);
    issue_command(OP_SEARCH, '1, '1);
    issue_command(OP_REMOVE, 31'd3, '0);
    issue_command(OP_UNUSED, '1, '1);
  endtask

  // direct mode overwrites the home slot regardless of its owner
  task automatic test_direct_insert();
    set_insert_policy(MODE_DIRECT);
    issue_command(OP_INSERT, '0, '0);
    issue_command(OP_INSERT, '1, '1);
    issue_command(OP_SEARCH, '0, '0);
    issue_command(OP_SEARCH, '1, '0);
    issue_command(OP_INSERT, 31'd32, 32'hA5A5_A5A5);
    issue_command(OP_SEARCH, '0, '0);
    issue_command(OP_SEARCH, 31'd32, '0);
    issue_command(OP_REMOVE, 31'd32, '0);
    issue_command(OP_SEARCH, 31'd32, '0);
  endtask

  // probe wraparound, quadratic skip and an exhausted double hash sequence
  task automatic test_probe_policies();
    set_insert_policy(MODE_LINEAR);
    issue_command(OP_INSERT, 31'd63, 32'h1234_5678);
    issue_command(OP_INSERT, 31'd95, 32'h8765_4321);
    set_insert_policy(MODE_QUADRATIC);
    issue_command(OP_INSERT, 31'd127, 32'h0F0F_0F0F);
    set_insert_policy(MODE_DOUBLE);
    issue_command(OP_INSERT, 31'd16, 32'hF0F0_F0F0);
    issue_command(OP_INSERT, 31'd48, 32'h5555_5555);
    issue_command(OP_INSERT, 31'd32, 32'hAAAA_AAAA);
    issue_command(OP_SEARCH, 31'd63, '0);
    issue_command(OP_SEARCH, 31'd16, '0);
  endtask

  // mixed random traffic over several policy settings
  task automatic test_random_traffic();
    mode_t phase_modes [8];
    int    roll;
    op_t   op;
    phase_modes = '{MODE_LINEAR, MODE_DIRECT, MODE_QUADRATIC, MODE_DOUBLE,
                    MODE_LINEAR, MODE_DOUBLE, MODE_QUADRATIC, MODE_DIRECT};
    for (int p = 0; p < 8; p++) begin
      set_insert_policy(phase_modes[p]);
      // last phase runs back to back
      idling = (p < 7);
      repeat (56) begin
        roll = $urandom_range(0, 99);
        if (roll < 45)      op = OP_INSERT;
        else if (roll < 65) op = OP_REMOVE;
        else if (roll < 95) op = OP_SEARCH;
        else                op = OP_UNUSED;
        issue_command(op, pick_key(), $urandom);
      end
    end
  endtask

  // result checker: each done strobe against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no command pending: status %0d slot %0d", status, slot);
        error_count++;
      end else begin
        oldest = expected_outcomes.pop_front();
        status_seen[oldest.st]++;
        if (status !== oldest.st) begin
          $error("status mismatch: expected %0d, actual %0d", oldest.st, status);
          error_count++;
        end
        if (slot !== oldest.sl) begin
          $error("slot mismatch: expected %0d, actual %0d", oldest.sl, slot);
          error_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    key       = '0;
    record    = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idling    = 1'b1;
    error_count = 0;
    commands_sent = 0;
    insert_policy = MODE_DIRECT;
    for (int s = 0; s < TABLE_SIZE; s++) begin
      key_word[s]  = 32'hFFFF_FFFF;
      slot_used[s] = 1'b0;
    end
    for (int s = 0; s < 4; s++) status_seen[s] = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_direct_insert();
    test_probe_policies();
    test_random_traffic();

    // drain, then leave room for any stray strobe
    wait_table_idle();
    repeat (40) @(posedge clk);

    $display("Ran %0d commands across direct, linear, quadratic and double hashing inserts.",
             commands_sent);
    $display("Results: %0d done, %0d table full, %0d found, %0d not found.",
             status_seen[ST_DONE], status_seen[ST_FULL], status_seen[ST_FOUND],
             status_seen[ST_MISS]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ohtab_pkg.sv
sv/ohtab_ram.sv
sv/ohtab_ctrl.sv
sv/ohtab_dp.sv
sv/open_addressing_hash_table.sv
sim/testbench.sv
